[sv/matrix_add_multiply_3x3_defines.svh]
// Assertion macros for the matrix add and multiply block.
// Used by the port checker; expects clk_i and rst_ni in scope.
`ifndef MATRIX_ADD_MULTIPLY_3X3_DEFINES_SVH
`define MATRIX_ADD_MULTIPLY_3X3_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset
`define MAM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset
`define MAM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/mam_pkg.sv]
`timescale 1ns / 1ps
// Shared types and result field widths for the matrix add and multiply block.
// No dependencies.
package mam_pkg;

  // Result field widths
  localparam int SUM_W  = 17;
  localparam int PROD_W = 33;
  localparam int IDX_W  = 2;

  // Read and compute command, one per store read
  typedef struct packed {
    logic             rd;
    logic             is_sum;
    logic             first_step;
    logic             final_step;
    logic             last;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } mam_cmd_t;

  // Store write enables
  typedef struct packed {
    logic we_a;
    logic we_b;
  } mam_wr_t;

  // Datapath status towards the controller
  typedef struct packed {
    logic busy;
    logic out_full;
  } mam_status_t;

endpackage

[sv/mam_stream_if.sv]
`timescale 1ns / 1ps
// Valid/ready stream interfaces for input elements and result items.
// Depends on mam_pkg for the result field widths.
interface mam_in_if #(
  parameter int ELEM_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [ELEM_WIDTH-1:0] elem_value;

  modport source (output valid, output elem_value, input ready);
  modport sink   (input valid, input elem_value, output ready);
endinterface

interface mam_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [mam_pkg::SUM_W-1:0]  sum_elem;
  logic signed [mam_pkg::PROD_W-1:0] product_elem;
  logic [mam_pkg::IDX_W-1:0]        row_index;
  logic [mam_pkg::IDX_W-1:0]        col_index;
  logic                             last_elem;

  modport source (
    output valid, output sum_elem, output product_elem,
    output row_index, output col_index, output last_elem, input ready
  );
  modport sink (
    input valid, input sum_elem, input product_elem,
    input row_index, input col_index, input last_elem, output ready
  );
endinterface

[sv/mam_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mam_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 9
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and read, read data registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/mam_ctrl.sv]
`timescale 1ns / 1ps
// Controller: load counter, result sequencing and store read addressing.
// Depends on mam_pkg for command and status types.
module mam_ctrl #(
  parameter int DIM = 3
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  output mam_pkg::mam_wr_t                    wr_o,
  output logic [$clog2(DIM*DIM)-1:0]          waddr_o,
  output mam_pkg::mam_cmd_t                   cmd_o,
  output logic [$clog2(DIM*DIM)-1:0]          raddr_a_o,
  output logic [$clog2(DIM*DIM)-1:0]          raddr_b_o,
  input  mam_pkg::mam_status_t                status_i
);

  localparam int CELLS = DIM * DIM;
  localparam int AW    = $clog2(CELLS);
  localparam int PW    = $clog2(2 * CELLS);
  localparam int IW    = $clog2(DIM);
  localparam int KW    = $clog2(DIM + 1);

  typedef enum logic [1:0] {
    S_LOAD,
    S_ISSUE,
    S_WAIT
  } state_e;

  state_e            state_q;
  logic [PW-1:0]     pos_q;
  logic [IW-1:0]     row_q;
  logic [IW-1:0]     col_q;
  logic [KW-1:0]     step_q;
  mam_pkg::mam_cmd_t cmd_q;
  logic [AW-1:0]     raddr_a_q;
  logic [AW-1:0]     raddr_b_q;

  logic          accept;
  logic          in_a;
  logic          pos_last;
  logic [IW-1:0] k_sel;
  logic [AW-1:0] a_addr;
  logic [AW-1:0] b_addr;
  logic          step_end;
  logic          res_last;
  logic          drained;

  // Load side: route each item to store A or B
  assign accept   = in_valid_i && (state_q == S_LOAD);
  assign in_a     = pos_q < PW'(CELLS);
  assign pos_last = pos_q == PW'(2 * CELLS - 1);
  assign waddr_o  = in_a ? AW'(pos_q) : AW'(pos_q - PW'(CELLS));
  assign wr_o.we_a = accept && in_a;
  assign wr_o.we_b = accept && !in_a;
  assign in_ready_o = (state_q == S_LOAD);

  // Read addresses: step zero fetches the pair for the sum, then one k per step
  assign k_sel    = (step_q == '0) ? col_q : IW'(step_q - KW'(1));
  assign a_addr   = AW'(row_q * DIM + k_sel);
  assign b_addr   = (step_q == '0) ? AW'(row_q * DIM + col_q) : AW'(k_sel * DIM + col_q);
  assign step_end = step_q == KW'(DIM);
  assign res_last = (row_q == IW'(DIM - 1)) && (col_q == IW'(DIM - 1));
  assign drained  = !cmd_q.rd && !status_i.busy;

  // State, counters and registered command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_LOAD;
      pos_q     <= '0;
      row_q     <= '0;
      col_q     <= '0;
      step_q    <= '0;
      cmd_q     <= '0;
      raddr_a_q <= '0;
      raddr_b_q <= '0;
    end else begin
      case (state_q)
        S_LOAD: begin
          cmd_q <= '0;
          if (accept) begin
            if (pos_last) begin
              pos_q   <= '0;
              row_q   <= '0;
              col_q   <= '0;
              step_q  <= '0;
              state_q <= S_ISSUE;
            end else begin
              pos_q <= pos_q + PW'(1);
            end
          end
        end
        S_ISSUE: begin
          cmd_q.rd         <= 1'b1;
          cmd_q.is_sum     <= (step_q == '0);
          cmd_q.first_step <= (step_q == KW'(1));
          cmd_q.final_step <= step_end;
          cmd_q.last       <= res_last;
          cmd_q.row        <= mam_pkg::IDX_W'(row_q);
          cmd_q.col        <= mam_pkg::IDX_W'(col_q);
          raddr_a_q        <= a_addr;
          raddr_b_q        <= b_addr;
          if (step_end) begin
            step_q  <= '0;
            state_q <= S_WAIT;
          end else begin
            step_q <= step_q + KW'(1);
          end
        end
        S_WAIT: begin
          cmd_q <= '0;
          // Hold until the pipeline drains and the result register is free
          if (drained && !status_i.out_full) begin
            if (res_last) begin
              state_q <= S_LOAD;
            end else begin
              if (col_q == IW'(DIM - 1)) begin
                col_q <= '0;
                row_q <= row_q + IW'(1);
              end else begin
                col_q <= col_q + IW'(1);
              end
              state_q <= S_ISSUE;
            end
          end
        end
        default: begin
          cmd_q   <= '0;
          state_q <= S_LOAD;
        end
      endcase
    end
  end

  assign cmd_o     = cmd_q;
  assign raddr_a_o = raddr_a_q;
  assign raddr_b_o = raddr_b_q;

endmodule

[sv/mam_dp.sv]
`timescale 1ns / 1ps
// Datapath: element stores, multiply-accumulate pipeline and result register.
// Depends on mam_pkg and mam_ram.
module mam_dp #(
  parameter int DIM        = 3,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [ELEM_WIDTH-1:0]                elem_i,
  input  mam_pkg::mam_wr_t                     wr_i,
  input  logic [$clog2(DIM*DIM)-1:0]           waddr_i,
  input  mam_pkg::mam_cmd_t                    cmd_i,
  input  logic [$clog2(DIM*DIM)-1:0]           raddr_a_i,
  input  logic [$clog2(DIM*DIM)-1:0]           raddr_b_i,
  output mam_pkg::mam_status_t                 status_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [mam_pkg::SUM_W-1:0]     out_sum_o,
  output logic signed [mam_pkg::PROD_W-1:0]    out_prod_o,
  output logic [mam_pkg::IDX_W-1:0]            out_row_o,
  output logic [mam_pkg::IDX_W-1:0]            out_col_o,
  output logic                                 out_last_o
);

  localparam int CELLS = DIM * DIM;

  logic [ELEM_WIDTH-1:0]          a_rd;
  logic [ELEM_WIDTH-1:0]          b_rd;
  logic signed [ELEM_WIDTH-1:0]   a_s;
  logic signed [ELEM_WIDTH-1:0]   b_s;
  logic signed [2*ELEM_WIDTH-1:0] mul;
  logic signed [ELEM_WIDTH:0]     add_w;

  mam_pkg::mam_cmd_t cmd1_q;
  mam_pkg::mam_cmd_t cmd2_q;

  logic signed [mam_pkg::PROD_W-1:0] prod_q;
  logic signed [mam_pkg::SUM_W-1:0]  sum_q;
  logic signed [mam_pkg::PROD_W-1:0] acc_q;
  logic signed [mam_pkg::PROD_W-1:0] acc_d;

  logic                              out_valid_q;
  logic signed [mam_pkg::SUM_W-1:0]  out_sum_q;
  logic signed [mam_pkg::PROD_W-1:0] out_prod_q;
  logic [mam_pkg::IDX_W-1:0]         out_row_q;
  logic [mam_pkg::IDX_W-1:0]         out_col_q;
  logic                              out_last_q;

  // Element stores
  mam_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(CELLS)) u_ram_a (
    .clk_i  (clk_i),
    .we_i   (wr_i.we_a),
    .waddr_i(waddr_i),
    .wdata_i(elem_i),
    .raddr_i(raddr_a_i),
    .rdata_o(a_rd)
  );

  mam_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(CELLS)) u_ram_b (
    .clk_i  (clk_i),
    .we_i   (wr_i.we_b),
    .waddr_i(waddr_i),
    .wdata_i(elem_i),
    .raddr_i(raddr_b_i),
    .rdata_o(b_rd)
  );

  // Stage one arithmetic on the read data
  assign a_s   = signed'(a_rd);
  assign b_s   = signed'(b_rd);
  assign mul   = a_s * b_s;
  assign add_w = (ELEM_WIDTH + 1)'(a_s) + (ELEM_WIDTH + 1)'(b_s);

  // Stage two accumulation, restarting on the first k
  assign acc_d = cmd2_q.first_step ? prod_q : acc_q + prod_q;

  // Command pipeline and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd1_q      <= '0;
      cmd2_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cmd1_q <= cmd_i;
      cmd2_q <= cmd1_q;
      if (cmd2_q.rd && cmd2_q.final_step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd1_q.rd) begin
      if (cmd1_q.is_sum) begin
        sum_q <= mam_pkg::SUM_W'(add_w);
      end else begin
        prod_q <= mam_pkg::PROD_W'(mul);
      end
    end
    if (cmd2_q.rd && !cmd2_q.is_sum) begin
      acc_q <= acc_d;
    end
    // Load the result register on the last k
    if (cmd2_q.rd && cmd2_q.final_step) begin
      out_sum_q  <= sum_q;
      out_prod_q <= acc_d;
      out_row_q  <= cmd2_q.row;
      out_col_q  <= cmd2_q.col;
      out_last_q <= cmd2_q.last;
    end
  end

  assign status_o.busy     = cmd1_q.rd || cmd2_q.rd;
  assign status_o.out_full = out_valid_q;

  assign out_valid_o = out_valid_q;
  assign out_sum_o   = out_sum_q;
  assign out_prod_o  = out_prod_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign out_last_o  = out_last_q;

endmodule

[sv/matrix_add_multiply_3x3.sv]
`timescale 1ns / 1ps
// Matrix add and multiply: loads A then B, one element per cycle (2*DIM*DIM elements).
// After the last element of B, each result is made by DIM + 1 reads through the single
// read port of each store, then the registered read, multiply and accumulate stages.
// Loading resumes after the last result.
// Reset clears the load counter, sequencer and result valid; store contents stay undefined.
module matrix_add_multiply_3x3 #(
  parameter int DIM        = 3,
  parameter int ELEM_WIDTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mam_in_if.sink    in_if,
  mam_out_if.source out_if
);

  localparam int AW = $clog2(DIM * DIM);

  mam_pkg::mam_wr_t     wr;
  mam_pkg::mam_cmd_t    cmd;
  mam_pkg::mam_status_t status;
  logic [AW-1:0]        waddr;
  logic [AW-1:0]        raddr_a;
  logic [AW-1:0]        raddr_b;
  logic                 in_ready;

  // Sequencer
  mam_ctrl #(.DIM(DIM)) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_if.valid),
    .in_ready_o(in_ready),
    .wr_o      (wr),
    .waddr_o   (waddr),
    .cmd_o     (cmd),
    .raddr_a_o (raddr_a),
    .raddr_b_o (raddr_b),
    .status_i  (status)
  );

  // Stores and arithmetic
  mam_dp #(.DIM(DIM), .ELEM_WIDTH(ELEM_WIDTH)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .elem_i     (in_if.elem_value),
    .wr_i       (wr),
    .waddr_i    (waddr),
    .cmd_i      (cmd),
    .raddr_a_i  (raddr_a),
    .raddr_b_i  (raddr_b),
    .status_o   (status),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .out_sum_o  (out_if.sum_elem),
    .out_prod_o (out_if.product_elem),
    .out_row_o  (out_if.row_index),
    .out_col_o  (out_if.col_index),
    .out_last_o (out_if.last_elem)
  );

  assign in_if.ready = in_ready;

endmodule

[sv/mam_checker.sv]
`timescale 1ns / 1ps
// Port checker for the matrix add and multiply block, bound to the top level.
// Depends on mam_pkg and the assertion macros header.
`include "matrix_add_multiply_3x3_defines.svh"

module mam_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_ready_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic signed [mam_pkg::SUM_W-1:0]  out_sum_i,
  input logic signed [mam_pkg::PROD_W-1:0] out_prod_i,
  input logic [mam_pkg::IDX_W-1:0]         out_row_i,
  input logic [mam_pkg::IDX_W-1:0]         out_col_i,
  input logic                              out_last_i
);

  localparam int PAY_W = mam_pkg::SUM_W + mam_pkg::PROD_W + 2 * mam_pkg::IDX_W + 1;

  logic [PAY_W-1:0] payload;
  logic             stall;
  logic             take_mid;

  assign payload  = {out_sum_i, out_prod_i, out_row_i, out_col_i, out_last_i};
  assign stall    = out_valid_i && !out_ready_i;
  assign take_mid = out_valid_i && out_ready_i && !out_last_i;

  // Result handshake
  `MAM_ASSERT_NXT(a_out_hold, stall, out_valid_i, "result withdrawn while stalled")
  `MAM_ASSERT_NXT(a_out_stable, stall, $stable(payload), "result changed while stalled")

  // Loading and computing never overlap the start of a result
  `MAM_ASSERT_IMP(a_rise_busy, $rose(out_valid_i), !in_ready_i, "result raised while loading")
  `MAM_ASSERT_NXT(a_mid_busy, take_mid, !in_ready_i, "load resumed before last result")

  // The final result sits on the diagonal
  `MAM_ASSERT_IMP(a_last_diag, out_valid_i && out_last_i, out_row_i == out_col_i, "last off diagonal")

endmodule

bind matrix_add_multiply_3x3 mam_checker u_mam_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready_i (in_if.ready),
  .out_valid_i(out_if.valid),
  .out_ready_i(out_if.ready),
  .out_sum_i  (out_if.sum_elem),
  .out_prod_i (out_if.product_elem),
  .out_row_i  (out_if.row_index),
  .out_col_i  (out_if.col_index),
  .out_last_i (out_if.last_elem)
);
